[hdl/fcsg_pkg.sv]
`timescale 1ns / 1ps

package fcsg_pkg;

	localparam int COORD_BITS = 12;
	localparam int COLOR_BITS = 24;
	localparam int RAD_BITS   = 5;
	localparam int MAX_RADIUS = 31;
	localparam int SPAN_BITS  = 14;
	localparam int SQ_BITS    = 2 * RAD_BITS;
	localparam int POS_BITS   = 3;
	localparam int DY_BITS    = RAD_BITS + 1;

	// One row in flight through the span pipeline.
	typedef struct packed {
		logic                          valid;
		logic [COORD_BITS-1:0]         cx;
		logic signed [SPAN_BITS-1:0]   row;
		logic [COLOR_BITS-1:0]         color;
		logic                          last;
		logic [SQ_BITS-1:0]            rem_val;
		logic [RAD_BITS-1:0]           root;
	} span_work_t;

	// One digit of a floor square root: keep the trial bit if its square still fits.
	function automatic span_work_t sqrt_step(input span_work_t w,
			input logic [POS_BITS-1:0] pos);
		span_work_t          nxt;
		logic [RAD_BITS-1:0] trial;
		logic [SQ_BITS-1:0]  sq;
		nxt   = w;
		trial = w.root | (RAD_BITS'(1) << pos);
		sq    = SQ_BITS'(trial) * SQ_BITS'(trial);
		if (sq <= w.rem_val)
			nxt.root = trial;
		return nxt;
	endfunction

endpackage

[hdl/fcsg_root.sv]
`timescale 1ns / 1ps

module fcsg_root (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fcsg_pkg::span_work_t   in_word,
	output fcsg_pkg::span_work_t   out_word
);

	fcsg_pkg::span_work_t stage_s2, stage_s3, stage_s4, stage_s5, stage_s6;

	// One result bit per stage, most significant first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s2 <= '0;
			stage_s3 <= '0;
			stage_s4 <= '0;
			stage_s5 <= '0;
			stage_s6 <= '0;
		end else begin
			stage_s2 <= fcsg_pkg::sqrt_step(in_word, fcsg_pkg::POS_BITS'(4));
			stage_s3 <= fcsg_pkg::sqrt_step(stage_s2, fcsg_pkg::POS_BITS'(3));
			stage_s4 <= fcsg_pkg::sqrt_step(stage_s3, fcsg_pkg::POS_BITS'(2));
			stage_s5 <= fcsg_pkg::sqrt_step(stage_s4, fcsg_pkg::POS_BITS'(1));
			stage_s6 <= fcsg_pkg::sqrt_step(stage_s5, fcsg_pkg::POS_BITS'(0));
		end
	end

	assign out_word = stage_s6;

endmodule

[hdl/filled_circle_span_generator_unit.sv]
`timescale 1ns / 1ps

// Channel   Handshake       Ports
// command   start / busy    center_x, center_y, radius, fill_color
// span      strobe          span_row, span_left, span_right, span_color, span_last
//
// A command of radius r gives 2r+1 spans, one per cycle, issued by the row sequencer.
// The next command is taken only once the sequencer has walked every row of the previous one.
// Each row passes stage 1, the square root in five stages and the output register.
// Reset clears the sequencer and all valid bits; the span receiver cannot stall,
// so the pipeline never holds.

module filled_circle_span_generator_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [fcsg_pkg::COORD_BITS-1:0]        center_x,
	input  logic [fcsg_pkg::COORD_BITS-1:0]        center_y,
	input  logic [fcsg_pkg::RAD_BITS-1:0]          radius,
	input  logic [fcsg_pkg::COLOR_BITS-1:0]        fill_color,
	output logic                                   strobe,
	output logic signed [fcsg_pkg::SPAN_BITS-1:0]  span_row,
	output logic signed [fcsg_pkg::SPAN_BITS-1:0]  span_left,
	output logic signed [fcsg_pkg::SPAN_BITS-1:0]  span_right,
	output logic [fcsg_pkg::COLOR_BITS-1:0]        span_color,
	output logic                                   span_last
);

	logic                                  active_q;
	logic [fcsg_pkg::COORD_BITS-1:0]       cx_q, cy_q;
	logic [fcsg_pkg::RAD_BITS-1:0]         r_q;
	logic [fcsg_pkg::COLOR_BITS-1:0]       color_q;
	logic signed [fcsg_pkg::DY_BITS-1:0]   dy_q;

	logic                                  accept;
	logic                                  row_last;
	logic [fcsg_pkg::RAD_BITS-1:0]         dy_abs;
	logic [fcsg_pkg::SQ_BITS-1:0]          r_sq, dy_sq;
	fcsg_pkg::span_work_t                  work_s1, root_word;

	logic                                  strobe_s7;
	logic signed [fcsg_pkg::SPAN_BITS-1:0] row_s7, left_s7, right_s7;
	logic [fcsg_pkg::COLOR_BITS-1:0]       color_s7;
	logic                                  last_s7;

	assign accept   = start && !busy;
	assign busy     = active_q;
	assign row_last = (dy_q == $signed({1'b0, r_q}));

	// Row sequencer: walks dy from -r to +r, one row per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			dy_q     <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			dy_q     <= -$signed({1'b0, radius});
		end else if (active_q) begin
			if (row_last)
				active_q <= 1'b0;
			else
				dy_q <= dy_q + fcsg_pkg::DY_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			r_q     <= radius;
			color_q <= fill_color;
		end
	end

	assign dy_abs = fcsg_pkg::RAD_BITS'(dy_q[fcsg_pkg::DY_BITS-1] ? -dy_q : dy_q);
	assign r_sq   = fcsg_pkg::SQ_BITS'(r_q) * fcsg_pkg::SQ_BITS'(r_q);
	assign dy_sq  = fcsg_pkg::SQ_BITS'(dy_abs) * fcsg_pkg::SQ_BITS'(dy_abs);

	// Stage 1: the value under the root, and the row number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_s1 <= '0;
		end else begin
			work_s1.valid   <= active_q;
			work_s1.cx      <= cx_q;
			work_s1.row     <= $signed({2'b00, cy_q})
				+ $signed({{(fcsg_pkg::SPAN_BITS - fcsg_pkg::DY_BITS){dy_q[fcsg_pkg::DY_BITS-1]}},
				dy_q});
			work_s1.color   <= color_q;
			work_s1.last    <= row_last;
			work_s1.rem_val <= r_sq - dy_sq;
			work_s1.root    <= '0;
		end
	end

	fcsg_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (work_s1),
		.out_word (root_word)
	);

	// Half-width never exceeds the radius, so the span stays inside the bounding box.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s7 <= 1'b0;
			row_s7    <= '0;
			left_s7   <= '0;
			right_s7  <= '0;
			color_s7  <= '0;
			last_s7   <= 1'b0;
		end else begin
			strobe_s7 <= root_word.valid;
			row_s7    <= root_word.row;
			left_s7   <= $signed({2'b00, root_word.cx})
				- $signed({(fcsg_pkg::SPAN_BITS - fcsg_pkg::RAD_BITS)'(0), root_word.root});
			right_s7  <= $signed({2'b00, root_word.cx})
				+ $signed({(fcsg_pkg::SPAN_BITS - fcsg_pkg::RAD_BITS)'(0), root_word.root});
			color_s7  <= root_word.color;
			last_s7   <= root_word.valid && root_word.last;
		end
	end

	assign strobe     = strobe_s7;
	assign span_row   = row_s7;
	assign span_left  = left_s7;
	assign span_right = right_s7;
	assign span_color = color_s7;
	assign span_last  = last_s7;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("sequencer not busy after taking a command");

	a_last_point: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && span_last) |-> (span_left == span_right))
		else $error("bottom span is wider than one pixel");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (span_left <= span_right))
		else $error("span left edge beyond right edge");

	a_last_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		span_last |-> strobe)
		else $error("last mark without a span word");

endmodule

[test/tb_filled_circle_span_generator_unit.sv]
`timescale 1ns / 1ps

module tb_filled_circle_span_generator_unit;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_CMDS  = 196;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 16;

	typedef logic signed [fcsg_pkg::SPAN_BITS-1:0] span_coord_t;

	typedef struct packed {
		span_coord_t                     row;
		span_coord_t                     first_col;
		span_coord_t                     last_col;
		logic [fcsg_pkg::COLOR_BITS-1:0] color;
		logic                            is_last;
	} span_word_t;

	typedef struct {
		int                              cx;
		int                              cy;
		int                              rad;
		logic [fcsg_pkg::COLOR_BITS-1:0] color;
		bit                              typed;
		int                              exp_row;
		int                              exp_first;
		int                              exp_last_col;
		bit                              exp_is_last;
	} circle_cmd_t;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [fcsg_pkg::COORD_BITS-1:0] center_x;
	logic [fcsg_pkg::COORD_BITS-1:0] center_y;
	logic [fcsg_pkg::RAD_BITS-1:0]   radius;
	logic [fcsg_pkg::COLOR_BITS-1:0] fill_color;
	logic                            strobe;
	span_coord_t                     span_row;
	span_coord_t                     span_left;
	span_coord_t                     span_right;
	logic [fcsg_pkg::COLOR_BITS-1:0] span_color;
	logic                            span_last;

	span_word_t  expected_spans[$];
	int          mismatches;
	int          quiet_cycles;
	circle_cmd_t directed_cmds[16];

	filled_circle_span_generator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.fill_color (fill_color),
		.strobe     (strobe),
		.span_row   (span_row),
		.span_left  (span_left),
		.span_right (span_right),
		.span_color (span_color),
		.span_last  (span_last)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int isqrt_floor(input int v);
		int s;
		s = 0;
		if (v <= 0)
			return 0;
		while ((s + 1) * (s + 1) <= v)
			s++;
		return s;
	endfunction

	// Queues the spans of one filled circle, top row first.
	function automatic void predict_circle_spans(input int cx, input int cy, input int rad_in,
			input logic [fcsg_pkg::COLOR_BITS-1:0] color);
		int rad;
		int row;
		int dy;
		int d;
		int lo;
		int hi;
		span_word_t w;
		rad = rad_in;
		if (rad > fcsg_pkg::MAX_RADIUS)
			rad = fcsg_pkg::MAX_RADIUS;
		for (row = cy - rad; row <= cy + rad; row++) begin
			dy = row - cy;
			d  = isqrt_floor(rad * rad - dy * dy);
			lo = cx - d;
			hi = cx + d;
			if (lo < cx - rad)
				lo = cx - rad;
			if (hi > cx + rad)
				hi = cx + rad;
			w.row       = span_coord_t'(row);
			w.first_col = span_coord_t'(lo);
			w.last_col  = span_coord_t'(hi);
			w.color     = color;
			w.is_last   = (row == cy + rad);
			expected_spans.push_back(w);
		end
	endfunction

	task automatic report_mismatch(input string field, input int exp_val, input int act_val);
		mismatches++;
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, exp_val,
			act_val);
	endtask

	// Drives one command from a falling edge and holds it until the block takes it.
	task automatic issue_circle(input circle_cmd_t c);
		span_word_t w;
		start      <= 1'b1;
		center_x   <= fcsg_pkg::COORD_BITS'(c.cx);
		center_y   <= fcsg_pkg::COORD_BITS'(c.cy);
		radius     <= fcsg_pkg::RAD_BITS'(c.rad);
		fill_color <= c.color;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (c.typed) begin
			w.row       = span_coord_t'(c.exp_row);
			w.first_col = span_coord_t'(c.exp_first);
			w.last_col  = span_coord_t'(c.exp_last_col);
			w.color     = c.color;
			w.is_last   = c.exp_is_last;
			expected_spans.push_back(w);
		end else begin
			predict_circle_spans(c.cx, c.cy, c.rad, c.color);
		end
		@(negedge clk);
	endtask

	// Lowers start for a while and scrambles the command lines, which the block must ignore.
	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			start      <= 1'b0;
			center_x   <= fcsg_pkg::COORD_BITS'($urandom);
			center_y   <= fcsg_pkg::COORD_BITS'($urandom);
			radius     <= fcsg_pkg::RAD_BITS'($urandom);
			fill_color <= fcsg_pkg::COLOR_BITS'($urandom);
			repeat (cycles) @(negedge clk);
		end
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40)
			return 0;
		if (p < 80)
			return $urandom_range(1, 3);
		if (p < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	function automatic int pick_coord();
		int p;
		p = $urandom_range(0, 9);
		if (p < 2)
			return $urandom_range(0, 40);
		if (p < 4)
			return $urandom_range(4055, 4095);
		return $urandom_range(0, 4095);
	endfunction

	function automatic circle_cmd_t random_circle();
		circle_cmd_t c;
		int p;
		p       = $urandom_range(0, 99);
		c.cx    = pick_coord();
		c.cy    = pick_coord();
		c.color = fcsg_pkg::COLOR_BITS'($urandom);
		c.typed = 1'b0;
		if (p < 60)
			c.rad = $urandom_range(0, 7);
		else if (p < 85)
			c.rad = $urandom_range(8, 23);
		else
			c.rad = $urandom_range(24, fcsg_pkg::MAX_RADIUS);
		return c;
	endfunction

	always @(posedge clk) begin
		span_word_t w;
		if (arst_n && strobe === 1'b1) begin
			if (expected_spans.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected span word, expected none, got row %0d cols %0d..%0d",
					$time, span_row, span_left, span_right);
			end else begin
				w = expected_spans.pop_front();
				if (span_row !== w.row)
					report_mismatch("span_row", int'(w.row), int'(span_row));
				if (span_left !== w.first_col)
					report_mismatch("span_left", int'(w.first_col), int'(span_left));
				if (span_right !== w.last_col)
					report_mismatch("span_right", int'(w.last_col), int'(span_right));
				if (span_color !== w.color)
					report_mismatch("span_color", int'(w.color), int'(span_color));
				if (span_last !== w.is_last)
					report_mismatch("span_last", int'(w.is_last), int'(span_last));
			end
		end
	end

	// The run is abandoned once no word has moved on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (start === 1'b1 && busy === 1'b0) || strobe === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		bit burst;
		circle_cmd_t c;
		mismatches   = 0;
		quiet_cycles = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		center_x     = '0;
		center_y     = '0;
		radius       = '0;
		fill_color   = '0;

		// Zero radius rows carry their single span in the table; the rest use the predictor.
		directed_cmds = '{
			'{0,    0,    0,  24'h000000, 1'b1, 0,    0,    0,    1'b1},
			'{4095, 4095, 0,  24'hFFFFFF, 1'b1, 4095, 4095, 4095, 1'b1},
			'{2047, 2048, 0,  24'h800000, 1'b1, 2048, 2047, 2047, 1'b1},
			'{0,    4095, 0,  24'h5A5A5A, 1'b1, 4095, 0,    0,    1'b1},
			'{0,    0,    31, 24'hFFFFFF, 1'b0, 0,    0,    0,    1'b0},
			'{4095, 4095, 31, 24'h000000, 1'b0, 0,    0,    0,    1'b0},
			'{0,    4095, 31, 24'hAAAAAA, 1'b0, 0,    0,    0,    1'b0},
			'{4095, 0,    31, 24'h555555, 1'b0, 0,    0,    0,    1'b0},
			'{2048, 2048, 1,  24'h123456, 1'b0, 0,    0,    0,    1'b0},
			'{100,  200,  2,  24'hABCDEF, 1'b0, 0,    0,    0,    1'b0},
			'{1000, 1000, 5,  24'h0F0F0F, 1'b0, 0,    0,    0,    1'b0},
			'{31,   31,   31, 24'hF0F0F0, 1'b0, 0,    0,    0,    1'b0},
			'{30,   3000, 30, 24'h00FF00, 1'b0, 0,    0,    0,    1'b0},
			'{3000, 17,   16, 24'hFF0000, 1'b0, 0,    0,    0,    1'b0},
			'{4064, 4064, 31, 24'h0000FF, 1'b0, 0,    0,    0,    1'b0},
			'{1234, 2345, 7,  24'h7E57AB, 1'b0, 0,    0,    0,    1'b0}
		};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed commands go in back to back, apart from one short pause midway.
		foreach (directed_cmds[i]) begin
			if (i == 8)
				idle_for(3);
			issue_circle(directed_cmds[i]);
		end

		// Gaps come in runs of ten commands, some runs with no idling at all.
		burst = 1'b0;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 10 == 0)
				burst = ($urandom_range(0, 3) == 0);
			c = random_circle();
			if (!burst)
				idle_for(pick_gap());
			issue_circle(c);
		end
		start <= 1'b0;

		while (expected_spans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
